[rtl/image_downsample_2x2_average_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the 2x2 downsampler
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef IMAGE_DOWNSAMPLE_2X2_AVERAGE_MACROS_SVH
`define IMAGE_DOWNSAMPLE_2X2_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define IDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define IDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define IDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/imgds_pkg.sv]
// ---------------------------------------------------------------------------
// imgds_pkg
// Sizes, register indexes and types of the 2x2 downsampler.
// ---------------------------------------------------------------------------
package imgds_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;

  localparam int CFG_W  = 11;
  localparam int PIX_W  = 8;
  localparam int PAIR_W = PIX_W + 1;
  localparam int SUM_W  = PIX_W + 2;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int IDX_W  = COL_W - 1;
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT);

  // Compare widths: wide enough for the register and for count + 1.
  localparam int WID_W  = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int HGT_W  = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

endpackage

[rtl/image_downsample_2x2_average.sv]
// ---------------------------------------------------------------------------
// image_downsample_2x2_average
// 2x2 box-filter downsampler with a line store of horizontal pair sums.
// ---------------------------------------------------------------------------
// Pixels enter in raster order, one per clock, and the block sustains one
// pixel per clock with no gaps while the receiver keeps up. Every output pixel
// is the floor of the mean of one 2x2 block. On an even row the sum of each
// horizontal pixel pair is written to a single line store (MAX_WIDTH/2
// entries, one write or one read per pixel); on the odd row below, the pixel
// closing a pair reads the stored sum at its acceptance into stage 1, and the
// result moves on to the output register as stage 1 advances. The input
// stalls only while a finished result waits in stage 1 behind a stalled
// output register. The line store has no clearing pass after reset. An odd
// last column or row is consumed without output. end_of_row marks the last
// pixel of each output row, end_of_frame the last pixel of the frame. Write
// image_width and image_height only while the block is idle; sizes below 2
// act as 2, widths above MAX_WIDTH and heights above 1024 are clamped.
// ---------------------------------------------------------------------------
`include "image_downsample_2x2_average_macros.svh"

module image_downsample_2x2_average
  import imgds_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  // input pixels
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_pixel,
  // output pixels
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_avg_pixel,
  output logic             out_end_of_row,
  output logic             out_end_of_frame
);

  // Configuration registers
  logic [CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the sizes to their legal ranges.
  logic [WID_W-1:0] w_eff, out_w;
  logic [HGT_W-1:0] h_eff, out_h;

  always_comb begin
    if (WID_W'(width_r) < WID_W'(2))             w_eff = WID_W'(2);
    else if (WID_W'(width_r) > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
    else                                           w_eff = WID_W'(width_r);
    if (HGT_W'(height_r) < HGT_W'(2))                h_eff = HGT_W'(2);
    else if (HGT_W'(height_r) > HGT_W'(HEIGHT_LIMIT)) h_eff = HGT_W'(HEIGHT_LIMIT);
    else                                               h_eff = HGT_W'(height_r);
    out_w = w_eff >> 1;
    out_h = h_eff >> 1;
  end

  // Position counters and the left pixel of the current pair
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] left_r;

  // Stage 1: pair sum waiting for the line-store read data
  logic              s1_valid_r, s1_valid_nxt;
  logic [PAIR_W-1:0] s1_pair_r;
  logic              s1_eor_r, s1_eof_r;
  logic [PAIR_W-1:0] line_rdata_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_avg_r;
  logic              out_eor_r, out_eof_r;

  logic              advance, in_accept;
  logic [IDX_W-1:0]  pair_idx;
  logic              in_cols, in_rows, col_odd, row_odd;
  logic              pair_active, line_wr, line_rd;
  logic              eor, eof;
  logic [PAIR_W-1:0] pair_sum;
  logic [SUM_W-1:0]  block_sum;

  // Stage 1 moves forward whenever the output register is free or draining.
  assign advance   = !out_valid_r || !out_stall;
  // Hold the input only while a finished result cannot move on.
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign pair_idx = col_r[COL_W-1:1];
  assign col_odd  = col_r[0];
  assign row_odd  = row_r[0];
  assign in_cols  = WID_W'(pair_idx) < out_w;
  assign in_rows  = HGT_W'(row_r[ROW_W-1:1]) < out_h;

  assign pair_active = in_accept && col_odd && in_cols && in_rows;
  assign line_wr     = pair_active && !row_odd;
  assign line_rd     = pair_active && row_odd;

  assign pair_sum = {1'b0, left_r} + {1'b0, in_pixel};
  assign eor      = WID_W'(pair_idx) == (out_w - WID_W'(1));
  assign eof      = eor && (HGT_W'(row_r[ROW_W-1:1]) == (out_h - HGT_W'(1)));

  // Advance column and row at the end of each pixel.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if ((WID_W'(col_r) + WID_W'(1)) >= w_eff) begin
        col_nxt = '0;
        if ((HGT_W'(row_r) + HGT_W'(1)) >= h_eff) row_nxt = '0;
        else                                        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (line_rd)      s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept && !col_odd) left_r <= in_pixel;
    end
  end

  // Line store of pair sums: one access per pixel, read data registered.
  logic [PAIR_W-1:0] line_mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (line_wr) line_mem[pair_idx] <= pair_sum;
    if (line_rd) line_rdata_r <= line_mem[pair_idx];
  end

  // Stage 1 payload: load with the read, hold while stalled.
  always_ff @(posedge clk) begin
    if (line_rd) begin
      s1_pair_r <= pair_sum;
      s1_eor_r  <= eor;
      s1_eof_r  <= eof;
    end
  end

  // Add the pair above and divide by four.
  assign block_sum = {1'b0, line_rdata_r} + {1'b0, s1_pair_r};

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_avg_r <= block_sum[SUM_W-1:2];
      out_eor_r <= s1_eor_r;
      out_eof_r <= s1_eof_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_avg_pixel    = out_avg_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  // Checks
  `IDS_ASSERT_IMPLY(a_stall_needs_s1, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  `IDS_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !advance, s1_valid_r && $stable(s1_pair_r))
  `IDS_ASSERT_IMPLY(a_eof_is_eor, clk, rst_n, out_valid_r && out_eof_r, out_eor_r)
  `IDS_ASSERT_IMPLY(a_one_access, clk, rst_n, line_wr, !line_rd)

endmodule

[tb/image_downsample_2x2_average_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// image_downsample_2x2_average_tb
// Self-checking bench for the 2x2 box-filter downsampler. A table of frames
// covers the reset sizes, the size extremes and clamps, odd sizes and a size
// change in mid-frame; random frames follow. Every output transaction is
// compared with a local model of the block, with random gaps on both sides
// and one long receiver hold-off.
// ---------------------------------------------------------------------------
module image_downsample_2x2_average_tb
  import imgds_pkg::*;
();

  localparam int HALF_PERIOD   = 10;
  localparam int SETTLE_CYCLES = 8;     // output register loads from stage 1 after acceptance
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 38;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int MAX_REPORTS   = 40;

  localparam int FILL_RANDOM = -1;      // pixel source: random per pixel
  localparam int NO_FIXED    = -1;      // no typed-in average for the frame
  localparam int WHOLE_FRAME = 0;       // pixel count: one frame from origin

  typedef struct packed {
    logic [PIX_W-1:0] avg;
    logic             eor;
    logic             eof;
  } downsampled_px_t;

  // One row of the directed plan: optional register writes, then a run of
  // pixels, either constant or random.
  typedef struct packed {
    bit set_w;
    int w;
    bit set_h;
    int h;
    int n_pix;
    int fill;
    int fixed_avg;
  } frame_row_t;

  localparam int NUM_ROWS = 16;
  localparam frame_row_t PLAN [NUM_ROWS] = '{
    // reset sizes: two full 640-wide rows of white
    '{1'b0, 0,    1'b0, 0,    1280,        255,         255},
    // cut the height under the third row: one dead row closes the frame
    '{1'b0, 0,    1'b1, 2,    640,         FILL_RANDOM, NO_FIXED},
    '{1'b1, 2,    1'b1, 2,    WHOLE_FRAME, 0,           0},
    '{1'b0, 0,    1'b0, 0,    WHOLE_FRAME, 255,         255},
    // sizes below the minimum act as 2
    '{1'b1, 0,    1'b1, 1,    WHOLE_FRAME, FILL_RANDOM, NO_FIXED},
    '{1'b1, 1,    1'b1, 0,    WHOLE_FRAME, FILL_RANDOM, NO_FIXED},
    // odd width and height: last column and row dropped
    '{1'b1, 5,    1'b1, 5,    WHOLE_FRAME, FILL_RANDOM, NO_FIXED},
    '{1'b1, 3,    1'b1, 4,    WHOLE_FRAME, 3,           3},
    // width above the maximum clamps; fills every line store entry
    '{1'b1, 2047, 1'b1, 2,    WHOLE_FRAME, FILL_RANDOM, NO_FIXED},
    '{1'b1, 1024, 1'b0, 0,    WHOLE_FRAME, 128,         128},
    // height above the limit clamps; row count runs to its top
    '{1'b1, 2,    1'b1, 2047, WHOLE_FRAME, FILL_RANDOM, NO_FIXED},
    '{1'b0, 0,    1'b1, 1024, WHOLE_FRAME, 7,           7},
    // shrink the width in mid-row: the pixel past the new width ends the row
    '{1'b1, 8,    1'b1, 4,    6,           FILL_RANDOM, NO_FIXED},
    '{1'b1, 4,    1'b0, 0,    13,          FILL_RANDOM, NO_FIXED},
    '{1'b1, 6,    1'b0, 0,    WHOLE_FRAME, FILL_RANDOM, NO_FIXED},
    '{1'b1, 7,    1'b1, 3,    WHOLE_FRAME, 200,         200}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [PIX_W-1:0] in_pixel;
  logic             out_valid;
  logic             out_stall;
  logic [PIX_W-1:0] out_avg_pixel;
  logic             out_end_of_row;
  logic             out_end_of_frame;

  // Model state of the block
  logic [CFG_W-1:0]  width_reg  = WIDTH_RESET;
  logic [CFG_W-1:0]  height_reg = HEIGHT_RESET;
  logic [PAIR_W-1:0] line_sum [LINE_DEPTH];
  logic [PIX_W-1:0]  left_px = '0;
  int                col_cnt = 0;
  int                row_cnt = 0;

  downsampled_px_t pending_px [$];
  int              fixed_avg = NO_FIXED;
  int              errors    = 0;
  int              idle_pct  = IDLE_PCT;
  bit              hold_req  = 1'b0;

  image_downsample_2x2_average dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_avg_pixel    (out_avg_pixel),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic int clamp_size(input int v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the model by one accepted pixel; queue the averaged pixel when
  // the pixel closes a 2x2 block on an odd row.
  task automatic predict_pixel(input logic [PIX_W-1:0] px);
    int                w, h, out_w, out_h, idx;
    logic [PAIR_W-1:0] pair;
    logic [SUM_W-1:0]  sum;
    downsampled_px_t   e;
    w     = clamp_size(int'(width_reg), MAX_WIDTH);
    h     = clamp_size(int'(height_reg), HEIGHT_LIMIT);
    out_w = w / 2;
    out_h = h / 2;
    idx   = (col_cnt / 2) % LINE_DEPTH;
    if (col_cnt % 2 == 0) begin
      left_px = px;
    end else if ((col_cnt / 2) < out_w && (row_cnt / 2) < out_h) begin
      pair = PAIR_W'(left_px) + PAIR_W'(px);
      if (row_cnt % 2 == 0) begin
        line_sum[idx] = pair;
      end else begin
        sum   = SUM_W'(line_sum[idx]) + SUM_W'(pair);
        e.avg = sum[SUM_W-1:2];
        e.eor = ((col_cnt / 2) == out_w - 1);
        e.eof = e.eor && ((row_cnt / 2) == out_h - 1);
        if (fixed_avg != NO_FIXED) e.avg = PIX_W'(fixed_avg);
        pending_px.push_back(e);
      end
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endtask

  // Write one register; hold the enable for exactly one edge.
  task automatic write_reg(input cfg_index_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg  = CFG_W'(value);
      CFG_IMAGE_HEIGHT: height_reg = CFG_W'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drain: drop valid, wait for every queued average, then let the pipeline
  // run dry.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer pixels one transaction at a time. Keep valid high across
  // back-to-back transactions; drop it only for a random gap.
  task automatic stream_pixels(input int count, input int fill);
    logic [PIX_W-1:0] px;
    int               sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        if (fill != FILL_RANDOM) px = PIX_W'(fill);
        else if ($urandom_range(7) == 0) px = $urandom_range(1) ? 8'hFF : 8'h00;
        else px = PIX_W'($urandom_range(255));
        in_valid <= 1'b1;
        in_pixel <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_pixel(px);
        sent++;
      end
    end
  endtask

  // Receiver: random stalls, or a long counted hold-off on request so the
  // block backs up and stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Compare every output transaction with the oldest queued average.
  always @(posedge clk) begin
    downsampled_px_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected output, actual avg=%0d eor=%0b eof=%0b",
                   $time, out_avg_pixel, out_end_of_row, out_end_of_frame);
        errors++;
      end else begin
        e = pending_px.pop_front();
        if (out_avg_pixel !== e.avg) begin
          if (errors < MAX_REPORTS)
            $display("%0t: avg_pixel expected %0d actual %0d",
                     $time, e.avg, out_avg_pixel);
          errors++;
        end
        if (out_end_of_row !== e.eor) begin
          if (errors < MAX_REPORTS)
            $display("%0t: end_of_row expected %0b actual %0b",
                     $time, e.eor, out_end_of_row);
          errors++;
        end
        if (out_end_of_frame !== e.eof) begin
          if (errors < MAX_REPORTS)
            $display("%0t: end_of_frame expected %0b actual %0b",
                     $time, e.eof, out_end_of_frame);
          errors++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    frame_row_t row;
    int         n, w_sel, h_sel, rand_items;
    bit         pressure_done;
    rand_items    = 0;
    pressure_done = 1'b0;
    for (int i = 0; i < LINE_DEPTH; i++) line_sum[i] = '0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_pixel  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan: walk the table, one frame (or part of one) per row.
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = PLAN[r];
      if (row.set_w || row.set_h) settle();
      if (row.set_w) write_reg(CFG_IMAGE_WIDTH, row.w);
      if (row.set_h) write_reg(CFG_IMAGE_HEIGHT, row.h);
      n = row.n_pix;
      if (n == WHOLE_FRAME)
        n = clamp_size(int'(width_reg), MAX_WIDTH) *
            clamp_size(int'(height_reg), HEIGHT_LIMIT);
      fixed_avg = row.fixed_avg;
      stream_pixels(n, row.fill);
    end
    fixed_avg = NO_FIXED;

    // Random frames: mostly small sizes, now and then out of range or wide.
    while (rand_items < RANDOM_ITEMS) begin
      idle_pct = (rand_items >= 350 && rand_items < 650) ? 0 : IDLE_PCT;
      settle();
      if (!pressure_done && rand_items >= 600) begin
        // Fill the block: hold the receiver off across a large frame.
        write_reg(CFG_IMAGE_WIDTH, 32);
        write_reg(CFG_IMAGE_HEIGHT, 16);
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end else begin
        case ($urandom_range(9))
          0:       w_sel = $urandom_range(1);
          1:       w_sel = $urandom_range(64, 17);
          default: w_sel = $urandom_range(16, 2);
        endcase
        h_sel = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(8, 2);
        if ($urandom_range(9) < 7) write_reg(CFG_IMAGE_WIDTH, w_sel);
        if ($urandom_range(9) < 7) write_reg(CFG_IMAGE_HEIGHT, h_sel);
      end
      n = clamp_size(int'(width_reg), MAX_WIDTH) *
          clamp_size(int'(height_reg), HEIGHT_LIMIT);
      stream_pixels(n, FILL_RANDOM);
      rand_items += n;
    end

    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
